// ----- rtl/core/dars_pkg.sv -----
package dars_pkg;

  // Per-channel sample ROM size and derived widths
  localparam int CHANNEL_ROM_BYTES = 65536;
  localparam int CHAN_AW           = $clog2(CHANNEL_ROM_BYTES);
  localparam int ROM_AW            = CHAN_AW + 1;
  localparam int ROM_DEPTH         = 2 ** ROM_AW;

  // Address register widths
  localparam int PLAY_W = 17;
  localparam int END_W  = 16;
  localparam int ADDR_SHIFT = 9;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_PLAY  = 2'd2,
    REG_STOP  = 2'd3
  } reg_sel_t;

  // What the back part does with a queued beat
  typedef enum logic [1:0] {
    KIND_CTRL  = 2'd0,
    KIND_HELD  = 2'd1,
    KIND_FETCH = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       ch;
    logic       conv_rst;
    logic [7:0] rom_byte;
  } dars_entry_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic       ch;
    logic       conv_rst;
  } dars_slot_t;

  typedef struct packed {
    logic              we;
    logic [ROM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [ROM_AW-1:0] raddr;
  } dars_ram_req_t;

endpackage

// ----- rtl/core/dars_in_if.sv -----
interface dars_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  reg_offset;
  logic [7:0]  data_byte;
  logic        tick_channel;
  logic [16:0] rom_address;

  modport source (output valid, func, reg_offset, data_byte, tick_channel, rom_address,
                  input ready);
  modport sink (input valid, func, reg_offset, data_byte, tick_channel, rom_address,
                output ready);
endinterface

// ----- rtl/core/dars_out_if.sv -----
interface dars_out_if;
  logic       valid;
  logic       ready;
  logic       out_channel;
  logic       converter_reset;
  logic [3:0] sample_nibble;
  logic       nibble_valid;

  modport source (output valid, out_channel, converter_reset, sample_nibble, nibble_valid,
                  input ready);
  modport sink (input valid, out_channel, converter_reset, sample_nibble, nibble_valid,
                output ready);
endinterface

// ----- rtl/core/dars_ram.sv -----
module dars_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/dars_front.sv -----
module dars_front import dars_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dars_in_if.sink           item,
  input  logic [QLVL_W-1:0] q_level,
  input  logic [7:0]        ram_rdata,
  output dars_ram_req_t     ram_req,
  output logic              push,
  output dars_entry_t       push_entry
);

  logic [PLAY_W-1:0] play [2];
  logic [END_W-1:0]  end_addr [2];
  logic [1:0]        idle;
  logic [1:0]        pending;
  dars_slot_t        slot;

  logic              acc;
  func_t             func;
  reg_sel_t          rsel;
  logic              wch;
  logic              tch;
  logic [PLAY_W-1:0] pos;
  logic              at_end;
  logic [CHAN_AW-1:0] load_off;
  logic              load_ok;

  // Keep room in the queue for the beat already in flight; hold off during reset
  assign item.ready = !rst && (({1'b0, q_level} + {{QLVL_W{1'b0}}, slot.valid})
                               < (QLVL_W + 1)'(QDEPTH));
  assign acc = item.valid && item.ready;

  // Classify the incoming beat
  assign func   = func_t'(item.func);
  assign rsel   = reg_sel_t'(item.reg_offset[2:1]);
  assign wch    = item.reg_offset[0];
  assign tch    = item.tick_channel;
  assign pos    = play[tch];
  assign at_end = (pos >= {1'b0, end_addr[tch]}) || (pos >= PLAY_W'(CHANNEL_ROM_BYTES));
  assign load_off = item.rom_address[CHAN_AW-1:0];
  assign load_ok  = {1'b0, item.rom_address[15:0]} < PLAY_W'(CHANNEL_ROM_BYTES);

  // Sample ROM access: write on load, read at the play address every cycle
  always_comb begin
    ram_req.we    = acc && (func == FUNC_LOAD) && load_ok;
    ram_req.waddr = {item.rom_address[16], load_off};
    ram_req.wdata = item.data_byte;
    ram_req.raddr = {tch, pos[CHAN_AW-1:0]};
  end

  // Update channel state and stage the beat descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      play[0]     <= '0;
      play[1]     <= '0;
      end_addr[0] <= '0;
      end_addr[1] <= '0;
      idle        <= '0;
      pending     <= '0;
      slot        <= '0;
    end else begin
      if (acc) begin
        unique case (func)
          FUNC_WRITE: begin
            unique case (rsel)
              REG_START: begin
                idle[wch] <= 1'b0;
                slot      <= '{valid: 1'b1, kind: KIND_CTRL, ch: wch, conv_rst: 1'b0};
              end
              REG_END: begin
                end_addr[wch] <= {item.data_byte[6:0], {ADDR_SHIFT{1'b0}}};
                slot.valid    <= 1'b0;
              end
              REG_PLAY: begin
                play[wch]  <= {1'b0, item.data_byte[6:0], {ADDR_SHIFT{1'b0}}};
                slot.valid <= 1'b0;
              end
              REG_STOP: begin
                idle[wch] <= 1'b1;
                slot      <= '{valid: 1'b1, kind: KIND_CTRL, ch: wch, conv_rst: 1'b1};
              end
              default: slot.valid <= 1'b0;
            endcase
          end
          FUNC_TICK: begin
            if (at_end) begin
              idle[tch] <= 1'b1;
              slot      <= '{valid: 1'b1, kind: KIND_CTRL, ch: tch, conv_rst: 1'b1};
            end else if (pending[tch]) begin
              pending[tch] <= 1'b0;
              slot <= '{valid: 1'b1, kind: KIND_HELD, ch: tch, conv_rst: idle[tch]};
            end else begin
              pending[tch] <= 1'b1;
              play[tch]    <= pos + PLAY_W'(1);
              slot <= '{valid: 1'b1, kind: KIND_FETCH, ch: tch, conv_rst: idle[tch]};
            end
          end
          default: slot.valid <= 1'b0;
        endcase
      end else begin
        slot.valid <= 1'b0;
      end
    end
  end

  // Join the staged descriptor with the ROM byte read in the same beat
  assign push = slot.valid;
  always_comb begin
    push_entry.kind     = slot.kind;
    push_entry.ch       = slot.ch;
    push_entry.conv_rst = slot.conv_rst;
    push_entry.rom_byte = ram_rdata;
  end

endmodule

// ----- rtl/core/dars_queue.sv -----
module dars_queue import dars_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dars_entry_t       push_entry,
  input  logic              pop,
  output dars_entry_t       head,
  output logic              head_valid,
  output logic [QLVL_W-1:0] level
);

  dars_entry_t       slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head       = slots[rd_ptr];
  assign head_valid = level != '0;

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + QLVL_W'(1);
      end else if (pop && !push) begin
        level <= level - QLVL_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/dars_back.sv -----
module dars_back import dars_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dars_entry_t head,
  input  logic        head_valid,
  output logic        pop,
  dars_out_if.source  result
);

  logic [3:0] low_held [2];

  // Take the next beat when the output register is free or draining
  assign pop = head_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      low_held[0]  <= '0;
      low_held[1]  <= '0;
    end else begin
      if (pop) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (pop && head.kind == KIND_FETCH) begin
        low_held[head.ch] <= head.rom_byte[3:0];
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      result.out_channel     <= head.ch;
      result.converter_reset <= head.conv_rst;
      unique case (head.kind)
        KIND_FETCH: begin
          result.sample_nibble <= head.rom_byte[7:4];
          result.nibble_valid  <= 1'b1;
        end
        KIND_HELD: begin
          result.sample_nibble <= low_held[head.ch];
          result.nibble_valid  <= 1'b1;
        end
        default: begin
          result.sample_nibble <= '0;
          result.nibble_valid  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/dual_adpcm_rom_sample_sequencer_unit.sv -----
// Two-channel ADPCM sample sequencer.
//
// The item channel carries bus writes, converter sample ticks and sample ROM
// load bytes. Start and stop writes and every sample tick produce one beat
// on the result channel; address writes, ROM loads and unused item kinds
// produce none.
//
// Throughput: one item per cycle while item ready is high. The front part
// updates the channel state and issues the ROM read at acceptance; the ROM's
// registered read port sets the staging stage ahead of the four-entry queue.
// A result passes the staging register, the queue and the output register
// before it is shown, and waits in the queue while the result side is stalled.
//
// Reset (rst, synchronous) clears both channels' addresses, idle flags and
// held nibbles; the sample ROM keeps its contents and must be loaded before
// it is played. When the receiver stalls, the output register holds, the
// queue fills, and item ready drops once the queue plus the staged beat
// reach its depth.
module dual_adpcm_rom_sample_sequencer_unit import dars_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dars_in_if.sink    item,
  dars_out_if.source result
);

  dars_ram_req_t     ram_req;
  logic [7:0]        ram_rdata;
  logic              push;
  dars_entry_t       push_entry;
  logic              pop;
  dars_entry_t       head;
  logic              head_valid;
  logic [QLVL_W-1:0] q_level;

  dars_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .q_level    (q_level),
    .ram_rdata  (ram_rdata),
    .ram_req    (ram_req),
    .push       (push),
    .push_entry (push_entry)
  );

  dars_ram #(
    .WIDTH (8),
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  dars_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (q_level)
  );

  dars_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && q_level == QLVL_W'(QDEPTH)))
    else $error("queue overflow");

  // Pop only from a non-empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_level != '0)
    else $error("queue underflow");

  // Every accepted tick stages a beat in the next cycle
  a_tick_staged: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.func == FUNC_TICK) |=> push)
    else $error("tick lost");

  // ROM loads and unused item kinds stage nothing
  a_silent_items: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && (item.func == FUNC_LOAD || item.func == FUNC_NONE))
      |=> !push)
    else $error("unexpected result beat");

endmodule
